[rtl/sfla_pkg.sv]
// Shared types, constants and state codes of the segregated free list allocator.
`default_nettype none
package sfla_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int AW         = $clog2(HEAP_WORDS);
  localparam int PW         = AW + 1;
  localparam int SW         = AW + 3;
  localparam int HEAP_BYTES = HEAP_WORDS * 4;
  localparam int MIN_BLOCK  = 8;

  typedef logic [PW-1:0] ptr_t;
  typedef logic [SW-1:0] bytes_t;
  typedef logic [AW-1:0] word_t;

  localparam ptr_t NIL_PTR = PW'(HEAP_WORDS);

  typedef enum logic [1:0] {
    FUNC_ALLOC       = 2'd0,
    FUNC_FREE        = 2'd1,
    FUNC_ALLOC_RETRY = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]    func;
    bytes_t        size_bytes;
    logic [AW+1:0] block_addr;
  } in_item_t;

  typedef struct packed {
    logic [AW+1:0] alloc_addr;
    logic          success;
    bytes_t        free_bytes;
  } out_item_t;

  typedef struct packed {
    logic   en;
    word_t  addr;
    bytes_t data;
  } size_wr_t;

  typedef struct packed {
    logic  en;
    word_t addr;
    ptr_t  data;
  } link_wr_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_INS_START,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_W1,
    ST_INS_W2,
    ST_FREE_END,
    ST_SM_START,
    ST_SM_RD,
    ST_SM_CHK,
    ST_UNLINK,
    ST_CARVE,
    ST_BG_START,
    ST_BG_RD,
    ST_BG_CHK,
    ST_MG_TEST,
    ST_MG_CHK,
    ST_BG_FIX,
    ST_BG_END,
    ST_CL_START,
    ST_CL_RD,
    ST_CL_CHK,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

[rtl/sfla_ram.sv]
// Generic single write port RAM with one registered read port.
`default_nettype none
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/sfla_ctrl.sv]
// Sequencer that walks, splits, merges and relinks the free lists in block memory.
`default_nettype none
module sfla_ctrl import sfla_pkg::*; #(
  parameter int NUM_SMALL_LISTS = 8,
  parameter int CLASS_SHIFT     = 5
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           res_valid_o,
  input  wire logic      res_ack_i,
  output out_item_t      res_data_o,
  output size_wr_t       size_wr_o,
  output link_wr_t       link_wr_o,
  output word_t          rd_addr_o,
  input  wire bytes_t    size_rdata_i,
  input  wire ptr_t      link_rdata_i
);

  localparam int NL = NUM_SMALL_LISTS + 1;
  localparam int LW = $clog2(NUM_SMALL_LISTS + 1);
  localparam logic [LW-1:0] BIG = LW'(NUM_SMALL_LISTS);
  localparam int INIT_RAW   = HEAP_BYTES >> CLASS_SHIFT;
  localparam int INIT_CLASS = (INIT_RAW >= NUM_SMALL_LISTS) ? NUM_SMALL_LISTS : INIT_RAW;

  function automatic logic [LW-1:0] class_of(input bytes_t b);
    bytes_t c;
    c = b >> CLASS_SHIFT;
    if (c >= SW'(NUM_SMALL_LISTS)) begin
      return BIG;
    end
    return c[LW-1:0];
  endfunction

  state_e state_q, state_d, ret_q, ret_d;
  ptr_t   heads_q [NL];
  ptr_t   heads_d [NL];
  bytes_t fcount_q, fcount_d;
  logic   found_q, found_d, merged_q, merged_d, retry_q, retry_d, ins_ok_q, ins_ok_d;

  logic [1:0]    func_q, func_d;
  bytes_t        need_q, need_d, sz_q, sz_d, best_sz_q, best_sz_d, best_diff_q, best_diff_d;
  bytes_t        ins_bytes_q, ins_bytes_d;
  logic [LW-1:0] lst_q, lst_d, ins_l_q, ins_l_d;
  ptr_t          cur_q, cur_d, prev_q, prev_d, nb_q, nb_d;
  ptr_t          best_q, best_d, best_prev_q, best_prev_d, best_next_q, best_next_d;
  ptr_t          icur_q, icur_d, iprev_q, iprev_d, ccur_q, ccur_d, ins_w_q, ins_w_d;
  logic [AW+1:0] res_addr_q, res_addr_d;
  logic          res_ok_q, res_ok_d;

  bytes_t        req_min, diff;
  logic [SW:0]   need_rnd, free_end, mg_end, fc_add;
  ptr_t          rw;
  logic          free_ok, mg_hit, bg_take;

  assign req_min  = (in_data_i.size_bytes < SW'(MIN_BLOCK)) ? SW'(MIN_BLOCK)
                                                            : in_data_i.size_bytes;
  assign need_rnd = ({1'b0, req_min} + (SW+1)'(3)) & ~(SW+1)'(3);
  assign free_end = (SW+1)'(in_data_i.block_addr) + (SW+1)'(in_data_i.size_bytes);
  assign free_ok  = (in_data_i.size_bytes >= SW'(MIN_BLOCK)) &&
                    (in_data_i.size_bytes[1:0] == 2'b00) &&
                    (in_data_i.block_addr[1:0] == 2'b00) &&
                    (free_end <= (SW+1)'(HEAP_BYTES));
  assign diff     = sz_q - need_q;
  assign rw       = cur_q + PW'(need_q >> 2);
  assign mg_end   = (SW+1)'({cur_q[AW-1:0], 2'b00}) + (SW+1)'(sz_q);
  assign mg_hit   = !nb_q[AW] && (mg_end == (SW+1)'({nb_q[AW-1:0], 2'b00}));
  assign fc_add   = (SW+1)'(fcount_q) + (SW+1)'(ins_bytes_q);
  assign bg_take  = (sz_q >= need_q) && (!found_q || ((sz_q - need_q) < best_diff_q));

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    heads_d     = heads_q;
    fcount_d    = fcount_q;
    found_d     = found_q;
    merged_d    = merged_q;
    retry_d     = retry_q;
    ins_ok_d    = ins_ok_q;
    func_d      = func_q;
    need_d      = need_q;
    sz_d        = sz_q;
    best_sz_d   = best_sz_q;
    best_diff_d = best_diff_q;
    ins_bytes_d = ins_bytes_q;
    lst_d       = lst_q;
    ins_l_d     = ins_l_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nb_d        = nb_q;
    best_d      = best_q;
    best_prev_d = best_prev_q;
    best_next_d = best_next_q;
    icur_d      = icur_q;
    iprev_d     = iprev_q;
    ccur_d      = ccur_q;
    ins_w_d     = ins_w_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    unique case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          func_d     = in_data_i.func;
          retry_d    = 1'b0;
          if (in_data_i.func == FUNC_ALLOC || in_data_i.func == FUNC_ALLOC_RETRY) begin
            if (need_rnd > (SW+1)'(HEAP_BYTES)) begin
              state_d = ST_DONE;
            end else begin
              need_d  = need_rnd[SW-1:0];
              lst_d   = class_of(need_rnd[SW-1:0]);
              state_d = ST_SM_START;
            end
          end else if (in_data_i.func == FUNC_FREE && free_ok) begin
            ins_w_d     = PW'(in_data_i.block_addr >> 2);
            ins_bytes_d = in_data_i.size_bytes;
            ins_l_d     = class_of(in_data_i.size_bytes);
            ret_d       = ST_FREE_END;
            state_d     = ST_INS_START;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_INS_START: begin
        icur_d  = heads_q[ins_l_q];
        iprev_d = NIL_PTR;
        state_d = ST_INS_RD;
      end
      ST_INS_RD: begin
        if (!icur_q[AW] && icur_q < ins_w_q) begin
          state_d = ST_INS_CHK;
        end else if (icur_q == ins_w_q) begin
          ins_ok_d = 1'b0;
          state_d  = ret_q;
        end else begin
          state_d = ST_INS_W1;
        end
      end
      ST_INS_CHK: begin
        iprev_d = icur_q;
        icur_d  = link_rdata_i;
        state_d = ST_INS_RD;
      end
      ST_INS_W1: state_d = ST_INS_W2;
      ST_INS_W2: begin
        if (iprev_q[AW]) begin
          heads_d[ins_l_q] = ins_w_q;
        end
        ins_ok_d = 1'b1;
        state_d  = ret_q;
      end
      ST_FREE_END: begin
        if (ins_ok_q) begin
          fcount_d = (fc_add > (SW+1)'(HEAP_BYTES)) ? SW'(HEAP_BYTES) : fc_add[SW-1:0];
          res_ok_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_SM_START: begin
        if (lst_q == BIG) begin
          state_d = ST_BG_START;
        end else begin
          cur_d   = heads_q[lst_q];
          prev_d  = NIL_PTR;
          state_d = ST_SM_RD;
        end
      end
      ST_SM_RD: begin
        if (!cur_q[AW]) begin
          state_d = ST_SM_CHK;
        end else begin
          lst_d   = lst_q + LW'(1);
          state_d = ST_SM_START;
        end
      end
      ST_SM_CHK: begin
        if (size_rdata_i < need_q) begin
          prev_d  = cur_q;
          cur_d   = link_rdata_i;
          state_d = ST_SM_RD;
        end else begin
          sz_d    = size_rdata_i;
          nb_d    = link_rdata_i;
          state_d = ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        if (prev_q[AW]) begin
          heads_d[lst_q] = nb_q;
        end
        state_d = ST_CARVE;
      end
      ST_CARVE: begin
        res_addr_d = {cur_q[AW-1:0], 2'b00};
        res_ok_d   = 1'b1;
        fcount_d   = (fcount_q >= need_q) ? fcount_q - need_q : '0;
        if (diff >= SW'(MIN_BLOCK) && !rw[AW]) begin
          ins_w_d     = rw;
          ins_bytes_d = diff;
          ins_l_d     = class_of(diff);
          ret_d       = ST_DONE;
          state_d     = ST_INS_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_BG_START: begin
        cur_d   = heads_q[BIG];
        prev_d  = NIL_PTR;
        found_d = 1'b0;
        state_d = ST_BG_RD;
      end
      ST_BG_RD: state_d = cur_q[AW] ? ST_BG_END : ST_BG_CHK;
      ST_BG_CHK: begin
        sz_d     = size_rdata_i;
        nb_d     = link_rdata_i;
        merged_d = 1'b0;
        state_d  = ST_MG_TEST;
      end
      ST_MG_TEST: state_d = mg_hit ? ST_MG_CHK : ST_BG_FIX;
      ST_MG_CHK: begin
        sz_d     = sz_q + size_rdata_i;
        nb_d     = link_rdata_i;
        merged_d = 1'b1;
        state_d  = ST_MG_TEST;
      end
      ST_BG_FIX: begin
        if (bg_take) begin
          found_d     = 1'b1;
          best_d      = cur_q;
          best_prev_d = prev_q;
          best_next_d = nb_q;
          best_sz_d   = sz_q;
          best_diff_d = sz_q - need_q;
        end
        prev_d  = cur_q;
        cur_d   = nb_q;
        state_d = ST_BG_RD;
      end
      ST_BG_END: begin
        if (found_q) begin
          lst_d   = BIG;
          prev_d  = best_prev_q;
          cur_d   = best_q;
          nb_d    = best_next_q;
          sz_d    = best_sz_q;
          state_d = ST_UNLINK;
        end else if (func_q == FUNC_ALLOC_RETRY && !retry_q) begin
          retry_d = 1'b1;
          lst_d   = '0;
          state_d = ST_CL_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CL_START: begin
        if (lst_q == BIG) begin
          lst_d   = class_of(need_q);
          state_d = ST_SM_START;
        end else begin
          ccur_d         = heads_q[lst_q];
          heads_d[lst_q] = NIL_PTR;
          state_d        = ST_CL_RD;
        end
      end
      ST_CL_RD: begin
        if (!ccur_q[AW]) begin
          state_d = ST_CL_CHK;
        end else begin
          lst_d   = lst_q + LW'(1);
          state_d = ST_CL_START;
        end
      end
      ST_CL_CHK: begin
        ins_w_d     = ccur_q;
        ins_bytes_d = size_rdata_i;
        ins_l_d     = BIG;
        ccur_d      = link_rdata_i;
        ret_d       = ST_CL_RD;
        state_d     = ST_INS_START;
      end
      ST_DONE: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    size_wr_o   = '0;
    link_wr_o   = '0;
    rd_addr_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        size_wr_o = '{en: 1'b1, addr: '0, data: SW'(HEAP_BYTES)};
        link_wr_o = '{en: 1'b1, addr: '0, data: NIL_PTR};
      end
      ST_INS_RD: rd_addr_o = icur_q[AW-1:0];
      ST_INS_W1: begin
        size_wr_o = '{en: 1'b1, addr: ins_w_q[AW-1:0], data: ins_bytes_q};
        link_wr_o = '{en: 1'b1, addr: ins_w_q[AW-1:0], data: icur_q};
      end
      ST_INS_W2: link_wr_o = '{en: !iprev_q[AW], addr: iprev_q[AW-1:0], data: ins_w_q};
      ST_SM_RD, ST_BG_RD: rd_addr_o = cur_q[AW-1:0];
      ST_MG_TEST: rd_addr_o = nb_q[AW-1:0];
      ST_UNLINK: link_wr_o = '{en: !prev_q[AW], addr: prev_q[AW-1:0], data: nb_q};
      ST_BG_FIX: begin
        size_wr_o = '{en: merged_q, addr: cur_q[AW-1:0], data: sz_q};
        link_wr_o = '{en: merged_q, addr: cur_q[AW-1:0], data: nb_q};
      end
      ST_CL_RD: rd_addr_o = ccur_q[AW-1:0];
      default: ;
    endcase
  end

  assign res_data_o = '{alloc_addr: res_addr_q, success: res_ok_q, free_bytes: fcount_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ret_q    <= ST_DONE;
      fcount_q <= SW'(HEAP_BYTES);
      found_q  <= 1'b0;
      merged_q <= 1'b0;
      retry_q  <= 1'b0;
      ins_ok_q <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        heads_q[i] <= (i == INIT_CLASS) ? '0 : NIL_PTR;
      end
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      fcount_q <= fcount_d;
      found_q  <= found_d;
      merged_q <= merged_d;
      retry_q  <= retry_d;
      ins_ok_q <= ins_ok_d;
      heads_q  <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    need_q      <= need_d;
    sz_q        <= sz_d;
    best_sz_q   <= best_sz_d;
    best_diff_q <= best_diff_d;
    ins_bytes_q <= ins_bytes_d;
    lst_q       <= lst_d;
    ins_l_q     <= ins_l_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    nb_q        <= nb_d;
    best_q      <= best_d;
    best_prev_q <= best_prev_d;
    best_next_q <= best_next_d;
    icur_q      <= icur_d;
    iprev_q     <= iprev_d;
    ccur_q      <= ccur_d;
    ins_w_q     <= ins_w_d;
    res_addr_q  <= res_addr_d;
    res_ok_q    <= res_ok_d;
  end

`ifndef ASSERT_OFF
  a_fcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= SW'(HEAP_BYTES))
    else $error("free count above heap size");
  a_ins_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_W2 && !iprev_q[AW]) |-> (iprev_q < ins_w_q))
    else $error("insert predecessor not below new block");
  a_carve_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CARVE) |-> (sz_q >= need_q))
    else $error("carved block smaller than request");
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !res_ack_i) |=> (state_q == ST_DONE && $stable(fcount_q)))
    else $error("result dropped before transfer");
`endif

endmodule
`default_nettype wire

[rtl/segregated_free_list_allocator.sv]
// Segregated-fit free list heap allocator: block memories, sequencer, output register.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one request: allocate,
// free, or allocate with collapse-and-retry. Output channel out_valid_o /
// out_stall_i / out_data_o returns one result per request (address, success,
// running free byte count). A transfer happens when valid is high and stall low.
// Requests run one at a time; latency is set by the list walks in the size and
// link memories. A free walks its class list to the first entry not below the
// freed address and links the block in. An allocation scans the small lists from
// its class upward, then walks the big list for a best fit, merging neighbors,
// unlinks and carves, and puts any remainder back on a list; a collapse adds one
// insert walk per small-list block. The result then passes the output register.
// The next request is accepted as soon as the result is handed to the output
// register, even while the receiver stalls that register; a second result then
// waits in the sequencer, holding in_stall_o high until the register drains.
// After reset the block writes the whole-heap block into word zero of the
// memories in its init state; in_stall_o is high while it does so.
`default_nettype none
module segregated_free_list_allocator import sfla_pkg::*; #(
  parameter int NUM_SMALL_LISTS = 8,
  parameter int CLASS_SHIFT     = 5
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  size_wr_t  size_wr;
  link_wr_t  link_wr;
  word_t     rd_addr;
  bytes_t    size_rdata;
  ptr_t      link_rdata;
  logic      res_valid, res_ack;
  out_item_t res_data;
  logic      out_valid_q;
  out_item_t out_data_q;

  sfla_ram #(.WIDTH(SW), .DEPTH(HEAP_WORDS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_wr.en),
    .waddr_i (size_wr.addr),
    .wdata_i (size_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (size_rdata)
  );

  sfla_ram #(.WIDTH(PW), .DEPTH(HEAP_WORDS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_wr.en),
    .waddr_i (link_wr.addr),
    .wdata_i (link_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  sfla_ctrl #(
    .NUM_SMALL_LISTS (NUM_SMALL_LISTS),
    .CLASS_SHIFT     (CLASS_SHIFT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .res_valid_o  (res_valid),
    .res_ack_i    (res_ack),
    .res_data_o   (res_data),
    .size_wr_o    (size_wr),
    .link_wr_o    (link_wr),
    .rd_addr_o    (rd_addr),
    .size_rdata_i (size_rdata),
    .link_rdata_i (link_rdata)
  );

  assign res_ack = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
